FILE: design/bbru_pkg.sv
// Package for the buddy bitmap range update block: field widths, action codes,
// microcode opcodes, jump conditions, control and status words, and the program ROM.
// Depends on nothing; every other file of the block imports it.
package bbru_pkg;

    localparam int NODES_DEFAULT = 31;
    localparam int COUNT_W       = 5;
    localparam int ACTION_W      = 2;
    localparam int START_W       = 5;
    localparam int LENGTH_W      = 5;
    localparam int TREE_W        = 31;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd31;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_FETCH    = 4'd0;
    localparam pc_t PC_DISPATCH = 4'd1;
    localparam pc_t PC_SET_TOP  = 4'd4;
    localparam pc_t PC_FILL     = 4'd6;
    localparam pc_t PC_SET_UP   = 4'd7;
    localparam pc_t PC_SET_NEXT = 4'd8;
    localparam pc_t PC_CLR_TOP  = 4'd9;
    localparam pc_t PC_CHAIN    = 4'd12;
    localparam pc_t PC_CLR_UP   = 4'd13;
    localparam pc_t PC_CLR_NEXT = 4'd14;
    localparam pc_t PC_EMIT     = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_WRITE,
        OP_SINIT,
        OP_FILL,
        OP_SET_UP,
        OP_INC,
        OP_CINIT,
        OP_CLR_I,
        OP_CHAIN,
        OP_CLR_UP,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_IS_SET,
        C_IS_CLEAR,
        C_I_DONE,
        C_BIT_I,
        C_BIT_I_CLEAR,
        C_LO_MORE,
        C_SET_UP_OK,
        C_CHAIN_MORE,
        C_CLR_UP_OK,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take;
        logic  stay;
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic is_set;
        logic is_clear;
        logic i_done;
        logic bit_i;
        logic lo_more;
        logic set_up_ok;
        logic chain_more;
        logic clr_up_ok;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{1'b1, 1'b1, OP_LOAD,   C_IN_VALID,    PC_DISPATCH};
            4'd1:    w = '{1'b0, 1'b0, OP_NOP,    C_IS_SET,      PC_SET_TOP};
            4'd2:    w = '{1'b0, 1'b0, OP_NOP,    C_IS_CLEAR,    PC_CLR_TOP};
            4'd3:    w = '{1'b0, 1'b0, OP_WRITE,  C_ALWAYS,      PC_EMIT};
            4'd4:    w = '{1'b0, 1'b0, OP_SINIT,  C_I_DONE,      PC_EMIT};
            4'd5:    w = '{1'b0, 1'b0, OP_NOP,    C_BIT_I,       PC_SET_NEXT};
            4'd6:    w = '{1'b0, 1'b0, OP_FILL,   C_LO_MORE,     PC_FILL};
            4'd7:    w = '{1'b0, 1'b0, OP_SET_UP, C_SET_UP_OK,   PC_SET_UP};
            4'd8:    w = '{1'b0, 1'b0, OP_INC,    C_ALWAYS,      PC_SET_TOP};
            4'd9:    w = '{1'b0, 1'b0, OP_CINIT,  C_I_DONE,      PC_EMIT};
            4'd10:   w = '{1'b0, 1'b0, OP_NOP,    C_BIT_I_CLEAR, PC_CLR_NEXT};
            4'd11:   w = '{1'b0, 1'b0, OP_CLR_I,  C_NEVER,       PC_FETCH};
            4'd12:   w = '{1'b0, 1'b0, OP_CHAIN,  C_CHAIN_MORE,  PC_CHAIN};
            4'd13:   w = '{1'b0, 1'b0, OP_CLR_UP, C_CLR_UP_OK,   PC_CLR_UP};
            4'd14:   w = '{1'b0, 1'b0, OP_INC,    C_ALWAYS,      PC_CLR_TOP};
            4'd15:   w = '{1'b0, 1'b1, OP_EMIT,   C_OUT_FREE,    PC_FETCH};
            default: w = '{1'b0, 1'b0, OP_NOP,    C_ALWAYS,      PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: design/bbru_ifs.sv
// Channel interfaces of the buddy bitmap range update block: input item,
// result item and configuration write. Depends on bbru_pkg for field widths.
interface bbru_in_if import bbru_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [START_W-1:0]  range_start;
    logic [LENGTH_W-1:0] range_length;
    logic                node_value;

    modport source (output valid, action, range_start, range_length, node_value,
                    input ready);
    modport sink   (input valid, action, range_start, range_length, node_value,
                    output ready);
endinterface

interface bbru_out_if import bbru_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TREE_W-1:0] tree_bits;

    modport source (output valid, tree_bits, input ready);
    modport sink   (input valid, tree_bits, output ready);
endinterface

interface bbru_cfg_if import bbru_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: design/buddy_bitmap_range_update_core.sv
// Top level of the buddy bitmap range update block: microcode sequencer and datapath.
// Depends on bbru_pkg, bbru_ifs, bbru_seq and bbru_dp.
//
//   channel     dir  handshake    payload
//   item_in     in   valid/ready  action, range_start, range_length, node_value
//   result_out  out  valid/ready  tree_bits
//   cfg         in   valid/ready  data (node_count)
//
// One item at a time; a write or unused action goes from fetch through the dispatch steps and the write step to emit.
// A range is worked one node at a time. The per-node subtree fill or leftmost chain and
// the ancestor walk take most of its time, because the sequencer steps them one level a
// cycle.
// Reset clears the bitmap and loads node_count with 31; cfg is always ready.
// A stalled result holds in the result register; the next item is accepted meanwhile
// and waits at its final step until the register is free.
module buddy_bitmap_range_update_core import bbru_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    bbru_in_if.sink    item_in,
    bbru_out_if.source result_out,
    bbru_cfg_if.sink   cfg
);

    ucode_t  ctrl;
    status_t status;

    bbru_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    bbru_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg),
        .ctrl       (ctrl),
        .status     (status)
    );

endmodule

FILE: design/bbru_seq.sv
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on bbru_pkg for the control word, status word and ROM.
module bbru_seq import bbru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ucode_t  ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic hit;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:       hit = 1'b0;
            C_ALWAYS:      hit = 1'b1;
            C_IN_VALID:    hit = status.in_valid;
            C_IS_SET:      hit = status.is_set;
            C_IS_CLEAR:    hit = status.is_clear;
            C_I_DONE:      hit = status.i_done;
            C_BIT_I:       hit = status.bit_i;
            C_BIT_I_CLEAR: hit = !status.bit_i;
            C_LO_MORE:     hit = status.lo_more;
            C_SET_UP_OK:   hit = status.set_up_ok;
            C_CHAIN_MORE:  hit = status.chain_more;
            C_CLR_UP_OK:   hit = status.clr_up_ok;
            C_OUT_FREE:    hit = status.out_free;
            default:       hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hit)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_fetch_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_FETCH && !status.in_valid) |=> pc_reg == PC_FETCH)
        else $error("sequencer left fetch without an item");

    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_EMIT && !status.out_free) |=> pc_reg == PC_EMIT)
        else $error("sequencer left emit while result register full");

    a_range_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == PC_SET_TOP || pc_reg == PC_CLR_TOP) && status.i_done)
        |=> pc_reg == PC_EMIT)
        else $error("range loop did not end at emit");

endmodule

FILE: design/bbru_dp.sv
// Datapath: node bitmap, node count register, range and walk index registers,
// and the result register. Executes one microcode operation per cycle.
// Depends on bbru_pkg and the channel interfaces in bbru_ifs.
module bbru_dp import bbru_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    bbru_in_if.sink     item_in,
    bbru_out_if.source  result_out,
    bbru_cfg_if.sink    cfg,
    input  ucode_t  ctrl,
    output status_t status
);

    localparam int W = ($clog2(NODES + 1) + 2 > 7) ? $clog2(NODES + 1) + 2 : 7;
    typedef logic [W-1:0] idx_t;
    localparam logic [NODES-1:0] ONE = NODES'(1);

    logic [NODES-1:0]    bits_reg, bits_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [TREE_W-1:0]   tree_reg, tree_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic                val_reg, val_next;
    idx_t i_reg, i_next;
    idx_t end_reg, end_next;
    idx_t lo_reg, lo_next;
    idx_t hi_reg, hi_next;
    idx_t c_reg, c_next;
    idx_t j_reg, j_next;

    idx_t             n;
    idx_t             stop;
    logic [START_W:0] sum;
    idx_t             lo2, hi2, j2, parent_c;
    logic             set_up_ok, clr_up_ok;
    logic [NODES-1:0] fill_mask;

    function automatic logic bit_at(logic [NODES-1:0] b, idx_t k);
        logic [NODES-1:0] sh;
        sh = b >> k;
        return sh[0];
    endfunction

    always_comb
    begin
        n = (idx_t'(count_reg) > idx_t'(NODES)) ? idx_t'(NODES) : idx_t'(count_reg);
        sum = {1'b0, item_in.range_start} + {1'b0, item_in.range_length};
        stop = (idx_t'(sum) > n) ? n : idx_t'(sum);
        lo2 = (lo_reg << 1) + idx_t'(1);
        hi2 = (hi_reg << 1) + idx_t'(2);
        j2 = (j_reg << 1) + idx_t'(1);
        parent_c = (c_reg - idx_t'(1)) >> 1;
        if (c_reg[0])
        begin
            set_up_ok = ((c_reg + idx_t'(1)) < n) && bit_at(bits_reg, c_reg + idx_t'(1));
        end
        else
        begin
            set_up_ok = (c_reg != '0) && bit_at(bits_reg, c_reg - idx_t'(1));
        end
        clr_up_ok = (c_reg != '0) && bit_at(bits_reg, parent_c);
        for (int k = 0; k < NODES; k++)
        begin
            fill_mask[k] = (idx_t'(k) >= lo_reg) && (idx_t'(k) <= hi_reg) && (idx_t'(k) < n);
        end
    end

    always_comb
    begin
        status.in_valid   = item_in.valid;
        status.is_set     = (action_reg == ACT_SET);
        status.is_clear   = (action_reg == ACT_CLEAR);
        status.i_done     = (i_reg >= end_reg);
        status.bit_i      = bit_at(bits_reg, i_reg);
        status.lo_more    = (lo2 < n);
        status.set_up_ok  = set_up_ok;
        status.chain_more = (j2 < n);
        status.clr_up_ok  = clr_up_ok;
        status.out_free   = !out_valid_reg;
    end

    assign item_in.ready        = ctrl.take;
    assign cfg.ready            = 1'b1;
    assign result_out.valid     = out_valid_reg;
    assign result_out.tree_bits = tree_reg;

    always_comb
    begin
        bits_next      = bits_reg;
        count_next     = cfg.valid ? cfg.data : count_reg;
        out_valid_next = (out_valid_reg && result_out.ready) ? 1'b0 : out_valid_reg;
        tree_next      = tree_reg;
        action_next    = action_reg;
        val_next       = val_reg;
        i_next         = i_reg;
        end_next       = end_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        c_next         = c_reg;
        j_next         = j_reg;
        case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                if (item_in.valid)
                begin
                    action_next = item_in.action;
                    val_next    = item_in.node_value;
                    i_next      = idx_t'(item_in.range_start);
                    end_next    = stop;
                end
            end
            OP_WRITE:
            begin
                if (action_reg == ACT_WRITE && i_reg < n)
                begin
                    bits_next = val_reg ? (bits_reg | (ONE << i_reg))
                                        : (bits_reg & ~(ONE << i_reg));
                end
            end
            OP_SINIT:
            begin
                lo_next = i_reg;
                hi_next = i_reg;
                c_next  = i_reg;
            end
            OP_FILL:
            begin
                bits_next = bits_reg | fill_mask;
                lo_next   = lo2;
                hi_next   = hi2;
            end
            OP_SET_UP:
            begin
                if (set_up_ok)
                begin
                    c_next    = parent_c;
                    bits_next = bits_reg | (ONE << parent_c);
                end
            end
            OP_INC:
            begin
                i_next = i_reg + idx_t'(1);
            end
            OP_CINIT:
            begin
                c_next = i_reg;
                j_next = i_reg;
            end
            OP_CLR_I:
            begin
                bits_next = bits_reg & ~(ONE << i_reg);
            end
            OP_CHAIN:
            begin
                if (j2 < n)
                begin
                    j_next    = j2;
                    bits_next = bits_reg & ~(ONE << j2);
                end
            end
            OP_CLR_UP:
            begin
                if (clr_up_ok)
                begin
                    c_next    = parent_c;
                    bits_next = bits_reg & ~(ONE << parent_c);
                end
            end
            OP_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    tree_next      = TREE_W'(bits_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg      <= bits_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tree_reg   <= tree_next;
        action_reg <= action_next;
        val_reg    <= val_next;
        i_reg      <= i_next;
        end_reg    <= end_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        c_reg      <= c_next;
        j_reg      <= j_next;
    end

endmodule

FILE: sim/buddy_bitmap_range_update_core_tb.sv
`timescale 1ns / 100ps
// Testbench for buddy_bitmap_range_update_core: sends set, clear, write and unused-action items, tracks
// the expected bitmap per item and checks every result in order, across node-count settings.
// Depends on bbru_pkg, the channel interfaces in bbru_ifs and the core itself.
module buddy_bitmap_range_update_core_tb;
    import bbru_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES        = 12;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 500;

    class bitmap_tracker;
        logic [TREE_W-1:0]  tree;
        logic [COUNT_W-1:0] node_count;
        logic [TREE_W-1:0]  bitmap_due[$];
        int unsigned        items;
        int unsigned        checked;
        int unsigned        failures;

        function new();
            tree       = '0;
            node_count = COUNT_RESET;
            items      = 0;
            checked    = 0;
            failures   = 0;
        endfunction

        function void load_count(logic [COUNT_W-1:0] value);
            node_count = value;
        endfunction

        function int pending();
            return bitmap_due.size();
        endfunction

        function void set_node(int i, int n);
            int lo;
            int hi;
            int k;
            int c;
            bit ok;
            if (tree[i])
                return;
            lo = i;
            hi = i;
            while (lo < n)
            begin
                for (k = lo; k <= hi && k < n; k++)
                    tree[k] = 1'b1;
                lo = 2 * lo + 1;
                hi = 2 * hi + 2;
            end
            c  = i;
            ok = 1'b1;
            while (c > 0 && ok)
            begin
                if (c % 2 == 0)
                    ok = tree[c - 1];
                else
                    ok = (c + 1 < n) ? tree[c + 1] : 1'b0;
                if (ok)
                begin
                    c = (c - 1) / 2;
                    tree[c] = 1'b1;
                end
            end
        endfunction

        function void clear_node(int i, int n);
            int j;
            bit going;
            if (!tree[i])
                return;
            tree[i] = 1'b0;
            j = i;
            while (2 * j + 1 < n)
            begin
                j = 2 * j + 1;
                tree[j] = 1'b0;
            end
            j = i;
            going = 1'b1;
            while (j > 0 && going)
            begin
                j = (j - 1) / 2;
                if (!tree[j])
                    going = 1'b0;
                else
                    tree[j] = 1'b0;
            end
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [START_W-1:0] first,
                                logic [LENGTH_W-1:0] span, logic value);
            int n;
            int stop;
            int i;
            n = (node_count > TREE_W) ? TREE_W : int'(node_count);
            stop = int'(first) + int'(span);
            if (stop > n)
                stop = n;
            case (act)
                ACT_SET:
                    for (i = int'(first); i < stop; i++)
                        set_node(i, n);
                ACT_CLEAR:
                    for (i = int'(first); i < stop; i++)
                        clear_node(i, n);
                ACT_WRITE:
                    if (int'(first) < n)
                        tree[first] = value;
                default:
                    ;
            endcase
            bitmap_due.push_back(tree);
            items++;
        endfunction

        function void check_bitmap(logic [TREE_W-1:0] got);
            logic [TREE_W-1:0] want;
            checked++;
            if (bitmap_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR at %0t: result %h with none expected", $time, got);
            end
            else
            begin
                want = bitmap_due.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("ERROR at %0t: result %0d tree_bits expected %h got %h",
                                 $time, checked, want, got);
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int unsigned   tx_idle_pct  = 0;
    int unsigned   rx_idle_pct  = 0;
    bit            hold_request = 1'b0;
    int unsigned   hold_left;
    int            phase_count [PHASES];
    int            phase_items [PHASES];
    bitmap_tracker tracker;

    bbru_in_if  item_ch ();
    bbru_out_if result_ch ();
    bbru_cfg_if cfg_ch ();

    buddy_bitmap_range_update_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random ready, or a long hold-off on request
    initial
    begin
        bit hold_taken;
        result_ch.ready = 1'b0;
        hold_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.load_count(cfg_ch.data);
            if (item_ch.valid && item_ch.ready)
                tracker.note_item(item_ch.action, item_ch.range_start, item_ch.range_length,
                                  item_ch.node_value);
            if (result_ch.valid && result_ch.ready)
                tracker.check_bitmap(result_ch.tree_bits);
        end
    end

    task automatic write_count(input logic [COUNT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [START_W-1:0] first,
                             input logic [LENGTH_W-1:0] span, input logic value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.range_start  <= first;
        item_ch.range_length <= span;
        item_ch.node_value   <= value;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        logic [ACTION_W-1:0] act;
        logic [START_W-1:0]  first;
        logic [LENGTH_W-1:0] span;
        int                  pick;
        pick = $urandom_range(99);
        if (pick < 40)
            act = ACT_SET;
        else if (pick < 75)
            act = ACT_CLEAR;
        else if (pick < 95)
            act = ACT_WRITE;
        else
            act = ACT_UNUSED;
        if (n > 0 && $urandom_range(99) < 85)
            first = START_W'($urandom_range(n - 1));
        else
            first = START_W'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 70)
            span = LENGTH_W'($urandom_range(4));
        else if (pick < 90)
            span = LENGTH_W'($urandom_range(12));
        else
            span = LENGTH_W'($urandom_range(31));
        send_item(act, first, span, 1'($urandom_range(1)));
    endtask

    task automatic drain(input int settle);
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int k;
        int mode;
        tracker = new();
        phase_count = '{31, 7, 2, 31, 0, 15, 6, 31, 1, 24, 31, 31};
        phase_items = '{300, 150, 100, 200, 30, 200, 120, 250, 40, 150, 200, 160};
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_SET;
        item_ch.range_start  = '0;
        item_ch.range_length = '0;
        item_ch.node_value   = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle_pct = 21;
        rx_idle_pct = 66;
        write_count(31);

        send_item(ACT_SET, 0, 0, 0);
        send_item(ACT_WRITE, 30, 0, 1);
        send_item(ACT_WRITE, 30, 31, 0);
        send_item(ACT_SET, 30, 31, 1);
        send_item(ACT_SET, 29, 1, 0);
        send_item(ACT_SET, 15, 16, 0);
        send_item(ACT_CLEAR, 0, 1, 0);
        send_item(ACT_CLEAR, 20, 3, 1);
        send_item(ACT_UNUSED, 5, 5, 1);
        send_item(ACT_SET, 0, 31, 0);
        send_item(ACT_CLEAR, 31, 31, 1);
        send_item(ACT_WRITE, 31, 0, 1);
        send_item(ACT_CLEAR, 0, 31, 0);
        send_item(ACT_SET, 1, 1, 0);
        send_item(ACT_SET, 2, 1, 0);
        send_item(ACT_CLEAR, 10, 0, 0);
        send_item(ACT_CLEAR, 22, 1, 0);
        send_item(ACT_WRITE, 0, 0, 0);
        send_item(ACT_WRITE, 0, 0, 1);
        send_item(ACT_SET, 3, 31, 1);
        send_item(ACT_CLEAR, 7, 2, 0);
        drain(SETTLE_CYCLES);
        write_count(2);
        send_item(ACT_SET, 1, 1, 0);
        send_item(ACT_SET, 2, 31, 1);
        send_item(ACT_CLEAR, 1, 31, 0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            mode = phase / 4;
            tx_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 66 : 0;
            rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 21 : 0;
            drain(SETTLE_CYCLES);
            write_count(COUNT_W'(phase_count[phase]));
            if (phase == 10)
                hold_request = 1'b1;
            for (k = 0; k < phase_items[phase]; k++)
                send_random(phase_count[phase]);
        end
        drain(END_CYCLES);

        $display("Covered %0d items: set, clear, write and unused actions over %0d node counts",
                 tracker.items, PHASES + 2);
        $display("from 0 to 31, with stalls on both sides and a long result hold-off; %0d checked.",
                 tracker.checked);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
